// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define DLT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define DLT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Same-cycle implication that also holds across reset.
`define DLT_ASSERT_ALW(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/dlt_pkg.sv =====
// Types, constants and the command frame table of the DMX line transmitter.
package dlt_pkg;

   localparam int STORE_SLOTS = 128;
   localparam int FRAME_BYTES = 10;
   localparam int SLOT_AW     = $clog2(STORE_SLOTS);
   localparam int BYTE_W      = $clog2(FRAME_BYTES + 1);
   localparam int CMD_BODY    = 9;

   // input modes
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_CMD   = 2'd2;

   // command codes
   localparam logic [2:0] CMD_TOGGLE    = 3'd0;
   localparam logic [2:0] CMD_ADDRESS   = 3'd1;
   localparam logic [2:0] CMD_LOCK      = 3'd2;
   localparam logic [2:0] CMD_UNLOCK    = 3'd3;
   localparam logic [2:0] CMD_KEEPALIVE = 3'd4;
   localparam logic [2:0] CMD_SET_CHAN  = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_START_OFFSET = 3'd0;
   localparam logic [2:0] CSR_BIT_TICKS    = 3'd1;
   localparam logic [2:0] CSR_STOP_TICKS   = 3'd2;
   localparam logic [2:0] CSR_BREAK_TICKS  = 3'd3;
   localparam logic [2:0] CSR_MAB_TICKS    = 3'd4;
   localparam logic [2:0] CSR_GAP_TICKS    = 3'd5;

   // register reset values
   localparam logic [6:0]  RST_START_OFFSET = 7'd0;
   localparam logic [15:0] RST_BIT_TICKS    = 16'd104;
   localparam logic [15:0] RST_STOP_TICKS   = 16'd208;
   localparam logic [15:0] RST_BREAK_TICKS  = 16'd3000;
   localparam logic [15:0] RST_MAB_TICKS    = 16'd525;
   localparam logic [15:0] RST_GAP_TICKS    = 16'd3000;

   // phase codes as shown on the result port
   localparam logic [1:0] PHASE_BREAK = 2'd0;
   localparam logic [1:0] PHASE_MAB   = 2'd1;
   localparam logic [1:0] PHASE_BYTES = 2'd2;
   localparam logic [1:0] PHASE_GAP   = 2'd3;

   // bit positions within a byte: start, data 1..8, stop
   localparam logic [3:0] BIT_START = 4'd0;
   localparam logic [3:0] BIT_STOP  = 4'd9;

   localparam logic [9:0] ADDR_MAX = 10'd512;

   localparam logic [7:0] CMD_TABLE [6][CMD_BODY] = '{
      '{8'h91, 8'h20, 8'h11, 8'h12, 8'hAB, 8'hCD, 8'h34, 8'hAB, 8'hCD},
      '{8'h91, 8'h20, 8'h11, 8'hAA, 8'h00, 8'h01, 8'h55, 8'h00, 8'h01},
      '{8'h91, 8'h20, 8'h11, 8'h12, 8'h4C, 8'h4F, 8'h34, 8'h43, 8'h4B},
      '{8'h91, 8'h20, 8'h11, 8'h12, 8'h75, 8'h6E, 8'h34, 8'h6C, 8'h6B},
      '{8'h91, 8'h20, 8'h11, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01},
      '{8'h91, 8'h20, 8'h11, 8'h77, 8'h00, 8'h01, 8'h33, 8'h00, 8'h01}
   };

   typedef struct packed {
      logic [6:0]  start_offset;
      logic [15:0] bit_ticks;
      logic [15:0] stop_ticks;
      logic [15:0] break_ticks;
      logic [15:0] mab_ticks;
      logic [15:0] gap_ticks;
   } cfg_type;

   // one classified item as it waits between front and back
   typedef struct packed {
      logic               wr;
      logic [SLOT_AW-1:0] slot;
      logic [7:0]         value;
      logic               req;
      logic [2:0]         command;
      logic [9:0]         address;
   } item_type;

   typedef struct packed {
      logic       line_level;
      logic [1:0] phase;
      logic       sending_command;
      logic       frame_done;
   } res_type;

   // Byte k of a command frame; the last byte is the running sum.
   function automatic logic [7:0] cmd_frame_byte(input logic [BYTE_W-1:0] k,
                                                 input logic [2:0] cmd,
                                                 input logic [9:0] addr,
                                                 input logic [7:0] sum);
      logic [2:0] c;
      logic [3:0] kk;
      logic [7:0] b;
      c  = (cmd <= CMD_SET_CHAN) ? cmd : CMD_TOGGLE;
      kk = 4'(k);
      if (32'(k) + 32'd1 == 32'(FRAME_BYTES)) begin
         b = sum;
      end else if (32'(k) >= 32'(CMD_BODY)) begin
         b = 8'h00;
      end else if (c == CMD_ADDRESS && (kk == 4'd4 || kk == 4'd7)) begin
         b = {6'd0, addr[9:8]};
      end else if (c == CMD_ADDRESS && (kk == 4'd5 || kk == 4'd8)) begin
         b = addr[7:0];
      end else begin
         b = CMD_TABLE[c][kk];
      end
      return b;
   endfunction

endpackage

// ===== sv/dmx_line_transmitter_unit.sv =====
// Top level of the DMX line transmitter: register bank, front end and line engine.
//
// Usage:
//  - Input side is a queue: present one item per timebase tick with req_push; it is
//    taken when req_full is low. Each item is one tick plus an optional slot write
//    (mode 1) or command request (mode 2).
//  - Result side is a queue: one result per item, shown while rsp_empty is low and
//    taken with rsp_pop. Results come out in item order.
//  - Registers are written by index via csr_valid/csr_ready (csr_ready is always high);
//    the user must do so only while the block is idle; the block does not enforce it.
//  - Path: an item, once taken, waits in the item queue; the line engine then steps
//    on it and writes its result into the result queue, from which it is popped.
//  - Throughput: one item per cycle while the result queue is not full or is popped;
//    the line engine steps once per item, with two-entry queues on both sides.
//  - When the receiver stalls, the result queue fills, the engine holds and the
//    item queue fills behind it, raising req_full; nothing is dropped.
//  - Reset clears both queues, returns the engine to the start of a break, drops
//    any pending command and marks every slot as zero (no clearing pass needed).
module dmx_line_transmitter_unit (
   input  logic        clock,
   input  logic        reset,
   // items
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [8:0]  req_channel,
   input  logic [7:0]  req_value,
   input  logic [2:0]  req_command,
   input  logic [9:0]  req_address,
   // results
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_line_level,
   output logic [1:0]  rsp_phase,
   output logic        rsp_sending_command,
   output logic        rsp_frame_done,
   // registers
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dlt_pkg::cfg_type  cfg_ff, cfg_in;
   dlt_pkg::item_type item;
   dlt_pkg::res_type  res;
   logic              item_valid;
   logic              item_take;

   assign csr_ready = 1'b1;

   // register bank; unknown indexes drop the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            dlt_pkg::CSR_START_OFFSET: cfg_in.start_offset = csr_wdata[6:0];
            dlt_pkg::CSR_BIT_TICKS:    cfg_in.bit_ticks    = csr_wdata;
            dlt_pkg::CSR_STOP_TICKS:   cfg_in.stop_ticks   = csr_wdata;
            dlt_pkg::CSR_BREAK_TICKS:  cfg_in.break_ticks  = csr_wdata;
            dlt_pkg::CSR_MAB_TICKS:    cfg_in.mab_ticks    = csr_wdata;
            dlt_pkg::CSR_GAP_TICKS:    cfg_in.gap_ticks    = csr_wdata;
            default:                   cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_offset <= dlt_pkg::RST_START_OFFSET;
         cfg_ff.bit_ticks    <= dlt_pkg::RST_BIT_TICKS;
         cfg_ff.stop_ticks   <= dlt_pkg::RST_STOP_TICKS;
         cfg_ff.break_ticks  <= dlt_pkg::RST_BREAK_TICKS;
         cfg_ff.mab_ticks    <= dlt_pkg::RST_MAB_TICKS;
         cfg_ff.gap_ticks    <= dlt_pkg::RST_GAP_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // accept and classify items, hold them in a short queue
   dlt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .full         (req_full),
      .mode         (req_mode),
      .channel      (req_channel),
      .value        (req_value),
      .command      (req_command),
      .address      (req_address),
      .start_offset (cfg_ff.start_offset),
      .item         (item),
      .item_valid   (item_valid),
      .item_take    (item_take)
   );

   // step the line one tick per item and queue the result
   dlt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .res        (res),
      .res_empty  (rsp_empty),
      .res_pop    (rsp_pop)
   );

   assign rsp_line_level      = res.line_level;
   assign rsp_phase           = res.phase;
   assign rsp_sending_command = res.sending_command;
   assign rsp_frame_done      = res.frame_done;

endmodule

// ===== sv/dlt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/dlt_front.sv =====
// Front end: accepts items, classifies them and queues them for the line engine.
module dlt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         mode,
   input  logic [8:0]         channel,
   input  logic [7:0]         value,
   input  logic [2:0]         command,
   input  logic [9:0]         address,
   input  logic [6:0]         start_offset,
   output dlt_pkg::item_type  item,
   output logic               item_valid,
   input  logic               item_take
);

   dlt_pkg::item_type cls;
   dlt_pkg::item_type q_ff [2];
   logic              wp_ff, wp_in;
   logic              rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [9:0]        ch_sum;
   logic [9:0]        ch_clamp;
   logic              do_push;
   logic              do_pop;

   // classify
   always_comb begin
      ch_sum = 10'(channel) + 10'(start_offset);
      if (ch_sum == 10'd0) begin
         ch_clamp = 10'd1;
      end else if (ch_sum > 10'(dlt_pkg::STORE_SLOTS - 1)) begin
         ch_clamp = 10'(dlt_pkg::STORE_SLOTS - 1);
      end else begin
         ch_clamp = ch_sum;
      end
      cls.wr      = (mode == dlt_pkg::MODE_WRITE);
      cls.slot    = dlt_pkg::SLOT_AW'(ch_clamp);
      cls.value   = value;
      cls.req     = (mode == dlt_pkg::MODE_CMD) && (command <= dlt_pkg::CMD_SET_CHAN);
      cls.command = command;
      cls.address = (address == 10'd0 || address > dlt_pkg::ADDR_MAX) ? 10'd1 : address;
   end

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rp_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      wp_in  = do_push ? !wp_ff : wp_ff;
      rp_in  = do_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

// ===== sv/dlt_back.sv =====
// Back end: slot store, line engine and result queue.
module dlt_back (
   input  logic              clock,
   input  logic              reset,
   input  dlt_pkg::cfg_type  cfg,
   input  dlt_pkg::item_type item,
   input  logic              item_valid,
   output logic              item_take,
   output dlt_pkg::res_type  res,
   output logic              res_empty,
   input  logic              res_pop
);

   localparam int AW = dlt_pkg::SLOT_AW;
   localparam int BW = dlt_pkg::BYTE_W;

   typedef enum logic [3:0] {
      PH_BREAK = 4'b0001,
      PH_MAB   = 4'b0010,
      PH_BYTES = 4'b0100,
      PH_GAP   = 4'b1000
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [15:0]                  tick_ff, tick_in;
   logic [3:0]                   bit_ff, bit_in;
   logic [BW-1:0]                byte_ff, byte_in;
   logic [7:0]                   shift_ff, shift_in;
   logic [7:0]                   sum_ff, sum_in;
   logic                         pend_ff, pend_in;
   logic [2:0]                   pend_cmd_ff, pend_cmd_in;
   logic [9:0]                   pend_addr_ff, pend_addr_in;
   logic                         act_ff, act_in;
   logic [2:0]                   act_cmd_ff, act_cmd_in;
   logic [9:0]                   act_addr_ff, act_addr_in;
   logic                         from_ram_ff, from_ram_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic                         rd_byp_ff, rd_byp_in;
   logic [7:0]                   byp_val_ff, byp_val_in;
   logic [dlt_pkg::STORE_SLOTS-1:0] valid_ff, valid_in;

   dlt_pkg::res_type             oq_ff [2];
   logic                         owp_ff, owp_in;
   logic                         orp_ff, orp_in;
   logic [1:0]                   ocnt_ff, ocnt_in;

   logic                         fire;
   logic                         pop_ok;
   logic                         pend_now;
   logic [2:0]                   pend_cmd_now;
   logic [9:0]                   pend_addr_now;
   logic                         latch;
   logic                         act_now;
   logic [15:0]                  len;
   logic [15:0]                  eff_len;
   logic                         ends;
   logic                         line;
   logic                         done;
   logic [1:0]                   phase_code;
   logic                         load_en;
   logic [BW-1:0]                load_k;
   logic [7:0]                   load_sum;
   logic [7:0]                   cmd_byte;
   logic [7:0]                   cur_byte;
   logic                         ram_we;
   logic                         ram_re;
   logic [AW-1:0]                ram_raddr;
   logic [7:0]                   ram_q;
   logic                         wr_hit;
   logic                         in_range;
   dlt_pkg::res_type             res_new;

   dlt_ram #(
      .WIDTH(8),
      .DEPTH(dlt_pkg::STORE_SLOTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (item.slot),
      .wdata (item.value),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

   assign pop_ok    = res_pop && (ocnt_ff != 2'd0);
   assign fire      = item_valid && (ocnt_ff != 2'd2 || pop_ok);
   assign item_take = fire;
   assign ram_we    = fire && item.wr;

   // byte being shifted out
   always_comb begin
      if (!from_ram_ff) begin
         cur_byte = shift_ff;
      end else if (!rd_valid_ff) begin
         cur_byte = 8'h00;
      end else if (rd_byp_ff) begin
         cur_byte = byp_val_ff;
      end else begin
         cur_byte = ram_q;
      end
   end

   always_comb begin
      case (phase_ff)
         PH_BREAK: phase_code = dlt_pkg::PHASE_BREAK;
         PH_MAB:   phase_code = dlt_pkg::PHASE_MAB;
         PH_BYTES: phase_code = dlt_pkg::PHASE_BYTES;
         PH_GAP:   phase_code = dlt_pkg::PHASE_GAP;
         default:  phase_code = dlt_pkg::PHASE_BREAK;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      byte_in      = byte_ff;
      shift_in     = shift_ff;
      sum_in       = sum_ff;
      pend_in      = pend_ff;
      pend_cmd_in  = pend_cmd_ff;
      pend_addr_in = pend_addr_ff;
      act_in       = act_ff;
      act_cmd_in   = act_cmd_ff;
      act_addr_in  = act_addr_ff;
      from_ram_in  = from_ram_ff;
      rd_valid_in  = rd_valid_ff;
      rd_byp_in    = rd_byp_ff;
      byp_val_in   = byp_val_ff;
      valid_in     = valid_ff;
      ram_re       = 1'b0;
      load_en      = 1'b0;
      load_k       = '0;
      load_sum     = 8'h00;
      line         = 1'b1;
      done         = 1'b0;
      len          = cfg.break_ticks;

      // request of this item lands before its tick
      pend_now      = item.req ? 1'b1 : pend_ff;
      pend_cmd_now  = item.req ? item.command : pend_cmd_ff;
      pend_addr_now = item.req ? item.address : pend_addr_ff;
      latch         = (phase_ff == PH_BREAK) && (tick_ff == 16'd0);
      act_now       = latch ? pend_now : act_ff;

      case (phase_ff)
         PH_BREAK: begin
            line = 1'b0;
            len  = cfg.break_ticks;
         end
         PH_MAB: begin
            len = cfg.mab_ticks;
         end
         PH_BYTES: begin
            if (bit_ff == dlt_pkg::BIT_START) begin
               line = 1'b0;
               len  = cfg.bit_ticks;
            end else if (bit_ff == dlt_pkg::BIT_STOP) begin
               len = cfg.stop_ticks;
            end else begin
               line = cur_byte[3'(bit_ff - 4'd1)];
               len  = cfg.bit_ticks;
            end
         end
         PH_GAP: begin
            len = cfg.gap_ticks;
         end
         default: begin
            len = cfg.break_ticks;
         end
      endcase

      eff_len = (len == 16'd0) ? 16'd1 : len;
      ends    = (17'(tick_ff) + 17'd1) >= 17'(eff_len);

      if (fire) begin
         pend_cmd_in  = pend_cmd_now;
         pend_addr_in = pend_addr_now;
         if (latch) begin
            act_in  = pend_now;
            pend_in = 1'b0;
            if (pend_now) begin
               act_cmd_in  = pend_cmd_now;
               act_addr_in = pend_addr_now;
            end
         end else begin
            pend_in = pend_now;
         end

         if (item.wr) begin
            valid_in[item.slot] = 1'b1;
         end

         if (!ends) begin
            tick_in = tick_ff + 16'd1;
         end else begin
            tick_in = 16'd0;
            case (phase_ff)
               PH_BREAK: begin
                  phase_in = PH_MAB;
               end
               PH_MAB: begin
                  phase_in = PH_BYTES;
                  bit_in   = dlt_pkg::BIT_START;
                  byte_in  = '0;
                  load_en  = 1'b1;
                  load_k   = '0;
                  load_sum = 8'h00;
               end
               PH_BYTES: begin
                  if (bit_ff != dlt_pkg::BIT_STOP) begin
                     bit_in = bit_ff + 4'd1;
                  end else if (32'(byte_ff) + 32'd1 >= 32'(dlt_pkg::FRAME_BYTES)) begin
                     done     = 1'b1;
                     phase_in = PH_GAP;
                     bit_in   = dlt_pkg::BIT_START;
                  end else begin
                     byte_in  = byte_ff + BW'(1);
                     bit_in   = dlt_pkg::BIT_START;
                     load_en  = 1'b1;
                     load_k   = byte_ff + BW'(1);
                     load_sum = sum_ff;
                  end
               end
               PH_GAP: begin
                  phase_in = PH_BREAK;
                  act_in   = 1'b0;
               end
               default: begin
                  phase_in = PH_BREAK;
               end
            endcase
         end
      end

      // fetch the next byte: command bytes come from the table, address and running sum, slots from the store
      cmd_byte  = dlt_pkg::cmd_frame_byte(load_k, act_cmd_ff, act_addr_ff, load_sum);
      in_range  = 32'(load_k) < 32'(dlt_pkg::STORE_SLOTS);
      ram_raddr = AW'(load_k);
      wr_hit    = ram_we && (item.slot == ram_raddr);
      if (load_en) begin
         if (act_ff) begin
            shift_in    = cmd_byte;
            sum_in      = load_sum + cmd_byte;
            from_ram_in = 1'b0;
         end else begin
            ram_re      = 1'b1;
            from_ram_in = 1'b1;
            rd_valid_in = in_range && (valid_ff[ram_raddr] || wr_hit);
            rd_byp_in   = wr_hit;
            byp_val_in  = item.value;
         end
      end

      res_new.line_level      = line;
      res_new.phase           = phase_code;
      res_new.sending_command = act_now;
      res_new.frame_done      = done;
   end

   // result queue
   assign res_empty = (ocnt_ff == 2'd0);
   assign res       = oq_ff[orp_ff];

   always_comb begin
      owp_in  = fire ? !owp_ff : owp_ff;
      orp_in  = pop_ok ? !orp_ff : orp_ff;
      ocnt_in = ocnt_ff + 2'(fire) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_BREAK;
         tick_ff      <= 16'd0;
         bit_ff       <= dlt_pkg::BIT_START;
         byte_ff      <= '0;
         shift_ff     <= 8'h00;
         sum_ff       <= 8'h00;
         pend_ff      <= 1'b0;
         pend_cmd_ff  <= dlt_pkg::CMD_TOGGLE;
         pend_addr_ff <= 10'd1;
         act_ff       <= 1'b0;
         act_cmd_ff   <= dlt_pkg::CMD_TOGGLE;
         act_addr_ff  <= 10'd1;
         from_ram_ff  <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rd_byp_ff    <= 1'b0;
         valid_ff     <= '0;
         owp_ff       <= 1'b0;
         orp_ff       <= 1'b0;
         ocnt_ff      <= 2'd0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         byte_ff      <= byte_in;
         shift_ff     <= shift_in;
         sum_ff       <= sum_in;
         pend_ff      <= pend_in;
         pend_cmd_ff  <= pend_cmd_in;
         pend_addr_ff <= pend_addr_in;
         act_ff       <= act_in;
         act_cmd_ff   <= act_cmd_in;
         act_addr_ff  <= act_addr_in;
         from_ram_ff  <= from_ram_in;
         rd_valid_ff  <= rd_valid_in;
         rd_byp_ff    <= rd_byp_in;
         valid_ff     <= valid_in;
         owp_ff       <= owp_in;
         orp_ff       <= orp_in;
         ocnt_ff      <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_val_ff <= byp_val_in;
      if (fire) begin
         oq_ff[owp_ff] <= res_new;
      end
   end

endmodule

// ===== sv/dlt_checker.sv =====
// Port-level checker for the DMX line transmitter, bound to the top level.
`include "assert_macros.svh"

module dlt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_line_level,
   input logic [1:0]  rsp_phase,
   input logic        rsp_sending_command,
   input logic        rsp_frame_done
);

   // a waiting result holds until taken
   `DLT_ASSERT_NXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_line_level) && $stable(rsp_phase) && $stable(rsp_sending_command) && $stable(rsp_frame_done))

   // both queues come out of reset empty
   `DLT_ASSERT_ALW(a_reset_empty, clock, $past(reset), rsp_empty && !req_full)

   // break drives the line low
   `DLT_ASSERT_IMP(a_break_low, clock, reset, !rsp_empty && rsp_phase == dlt_pkg::PHASE_BREAK, !rsp_line_level)

   // mark after break and gap drive the line high
   `DLT_ASSERT_IMP(a_mark_high, clock, reset, !rsp_empty && (rsp_phase == dlt_pkg::PHASE_MAB || rsp_phase == dlt_pkg::PHASE_GAP), rsp_line_level)

   // frame end is flagged only in the stop time of the byte phase
   `DLT_ASSERT_IMP(a_done_stop, clock, reset, !rsp_empty && rsp_frame_done, rsp_phase == dlt_pkg::PHASE_BYTES && rsp_line_level)

endmodule

bind dmx_line_transmitter_unit dlt_checker u_dlt_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for the DMX line transmitter unit: queue-driven stimulus and line check.
`timescale 1ns / 100ps

module tb;

   // codes the package leaves unnamed but the fields can still carry
   localparam logic [1:0] MODE_SPARE  = 2'd3;
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;
   localparam logic [2:0] CSR_SPARE_A = 3'd6;
   localparam logic [2:0] CSR_SPARE_B = 3'd7;

   localparam int RESET_CYCLES   = 9;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int LATENCY_TAIL   = 16;
   localparam int RUN_LIMIT_NS   = 2_000_000;

   // one tick as presented on the req_ ports
   typedef struct packed {
      logic [1:0] mode;
      logic [8:0] channel;
      logic [7:0] value;
      logic [2:0] command;
      logic [9:0] address;
   } tick_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   tick_item_type    drv_item = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   logic             rsp_line_level;
   logic [1:0]       rsp_phase;
   logic             rsp_sending_command;
   logic             rsp_frame_done;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_index = dlt_pkg::CSR_START_OFFSET;
   logic [15:0]      csr_wdata = '0;

   // ticks waiting to be driven, and line levels waiting to be seen
   tick_item_type    tick_q[$];
   dlt_pkg::res_type line_expect_q[$];
   dlt_pkg::res_type fresh_line;
   logic             fresh_vld = 1'b0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_tokens    = 0;
   int unsigned hold_taken     = 0;
   int unsigned hold_left      = 0;

   int unsigned fail_count   = 0;
   int unsigned ticks_sent   = 0;
   int unsigned levels_seen  = 0;
   int unsigned frames_seen  = 0;
   int unsigned cmd_frames   = 0;
   int unsigned full_stalls  = 0;

   // mirror of the line engine
   dlt_pkg::cfg_type m_cfg;
   logic [7:0]  m_slots [dlt_pkg::STORE_SLOTS];
   logic [1:0]  m_phase;
   logic [15:0] m_count;
   logic [3:0]  m_bit;
   int unsigned m_byte;
   logic [7:0]  m_shift;
   logic [7:0]  m_sum;
   logic        m_pend;
   logic [2:0]  m_pend_cmd;
   logic [9:0]  m_pend_addr;
   logic        m_cmd_on;
   logic [2:0]  m_act_cmd;
   logic [9:0]  m_act_addr;

   dmx_line_transmitter_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_mode            (drv_item.mode),
      .req_channel         (drv_item.channel),
      .req_value           (drv_item.value),
      .req_command         (drv_item.command),
      .req_address         (drv_item.address),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_line_level      (rsp_line_level),
      .rsp_phase           (rsp_phase),
      .rsp_sending_command (rsp_sending_command),
      .rsp_frame_done      (rsp_frame_done),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A zero length counts as one tick; a length already passed ends the interval now.
   function automatic logic interval_over(input logic [15:0] len);
      int unsigned need;
      need = (len == 16'd0) ? 32'd1 : 32'(len);
      return (32'(m_count) + 32'd1) >= need;
   endfunction

   // Byte k of the frame on the line: slot data for a refresh, table plus sum for a command.
   function automatic logic [7:0] frame_byte_at(input int unsigned k);
      int unsigned c;
      if (!m_cmd_on)
         return (k < dlt_pkg::STORE_SLOTS) ? m_slots[k] : 8'h00;
      if (k + 1 == dlt_pkg::FRAME_BYTES)
         return m_sum;
      if (k >= dlt_pkg::CMD_BODY)
         return 8'h00;
      c = (m_act_cmd <= dlt_pkg::CMD_SET_CHAN) ? 32'(m_act_cmd) : 32'(dlt_pkg::CMD_TOGGLE);
      if (c == 32'(dlt_pkg::CMD_ADDRESS)) begin
         // address goes in twice, high byte first
         if (k == 4 || k == 7)
            return {6'd0, m_act_addr[9:8]};
         if (k == 5 || k == 8)
            return m_act_addr[7:0];
      end
      return dlt_pkg::CMD_TABLE[c][k];
   endfunction

   function automatic void load_frame_byte();
      m_shift = frame_byte_at(m_byte);
      m_sum   = m_sum + m_shift;
   endfunction

   // Advance the mirror by one tick and return the line state that tick shows.
   function automatic dlt_pkg::res_type predict_line_tick(input tick_item_type it);
      dlt_pkg::res_type r;
      int unsigned      slot;
      logic [15:0]      len;
      r = '0;
      r.line_level = 1'b1;
      // the write or request of a tick lands before the tick goes out
      if (it.mode == dlt_pkg::MODE_WRITE) begin
         slot = 32'(it.channel) + 32'(m_cfg.start_offset);
         if (slot < 1)
            slot = 1;
         else if (slot > dlt_pkg::STORE_SLOTS - 1)
            slot = dlt_pkg::STORE_SLOTS - 1;
         m_slots[slot] = it.value;
      end else if (it.mode == dlt_pkg::MODE_CMD && it.command <= dlt_pkg::CMD_SET_CHAN) begin
         m_pend      = 1'b1;
         m_pend_cmd  = it.command;
         m_pend_addr = (it.address == 10'd0 || it.address > dlt_pkg::ADDR_MAX) ?
                       10'd1 : it.address;
      end
      // latch a queued command on the first tick of a break
      if (m_phase == dlt_pkg::PHASE_BREAK && m_count == 16'd0) begin
         m_cmd_on = m_pend;
         if (m_pend) begin
            m_act_cmd  = m_pend_cmd;
            m_act_addr = m_pend_addr;
         end
         m_pend = 1'b0;
      end
      r.phase           = m_phase;
      r.sending_command = m_cmd_on;
      case (m_phase)
         dlt_pkg::PHASE_BREAK: begin
            r.line_level = 1'b0;
            if (interval_over(m_cfg.break_ticks)) begin
               m_phase = dlt_pkg::PHASE_MAB;
               m_count = '0;
            end else begin
               m_count++;
            end
         end
         dlt_pkg::PHASE_MAB: begin
            if (interval_over(m_cfg.mab_ticks)) begin
               m_phase = dlt_pkg::PHASE_BYTES;
               m_count = '0;
               m_byte  = 0;
               m_bit   = dlt_pkg::BIT_START;
               m_sum   = '0;
               load_frame_byte();
            end else begin
               m_count++;
            end
         end
         dlt_pkg::PHASE_BYTES: begin
            if (m_bit == dlt_pkg::BIT_START) begin
               r.line_level = 1'b0;
               len = m_cfg.bit_ticks;
            end else if (m_bit < dlt_pkg::BIT_STOP) begin
               r.line_level = m_shift[m_bit - 4'd1];
               len = m_cfg.bit_ticks;
            end else begin
               len = m_cfg.stop_ticks;
            end
            if (interval_over(len)) begin
               m_count = '0;
               if (m_bit < dlt_pkg::BIT_STOP) begin
                  m_bit++;
               end else if (m_byte + 1 >= dlt_pkg::FRAME_BYTES) begin
                  r.frame_done = 1'b1;
                  m_phase      = dlt_pkg::PHASE_GAP;
                  m_bit        = dlt_pkg::BIT_START;
               end else begin
                  m_byte++;
                  m_bit = dlt_pkg::BIT_START;
                  load_frame_byte();
               end
            end else begin
               m_count++;
            end
         end
         default: begin
            if (interval_over(m_cfg.gap_ticks)) begin
               m_phase  = dlt_pkg::PHASE_BREAK;
               m_count  = '0;
               m_cmd_on = 1'b0;
            end else begin
               m_count++;
            end
         end
      endcase
      return r;
   endfunction

   function automatic tick_item_type mk_tick(input logic [1:0] mode, input logic [8:0] channel,
                                             input logic [7:0] value, input logic [2:0] command,
                                             input logic [9:0] address);
      tick_item_type it;
      it = '{mode, channel, value, command, address};
      return it;
   endfunction

   // Mostly plain ticks with slot writes; command requests are rare so that
   // refresh frames still get through between command frames.
   function automatic tick_item_type rand_tick();
      tick_item_type it;
      int unsigned   r;
      it.mode    = dlt_pkg::MODE_TICK;
      it.channel = 9'($urandom_range(511));
      it.value   = 8'($urandom);
      it.command = 3'($urandom_range(7));
      it.address = 10'($urandom_range(1023));
      r = $urandom_range(999);
      if (r < 180) begin
         it.mode = dlt_pkg::MODE_WRITE;
         // aim about half of the writes at low channels, near the slots that a frame sends
         if ($urandom_range(1) == 0)
            it.channel = 9'($urandom_range(12));
      end else if (r < 190) begin
         it.mode = dlt_pkg::MODE_CMD;
         case ($urandom_range(5))
            0: it.address = 10'd0;
            1: it.address = 10'd1;
            2: it.address = dlt_pkg::ADDR_MAX;
            3: it.address = dlt_pkg::ADDR_MAX + 10'd1;
            default: ;
         endcase
      end else if (r < 210) begin
         it.mode = MODE_SPARE;
      end
      return it;
   endfunction

   function automatic void check_field(input string name, input logic [1:0] want,
                                       input logic [1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Write one register and track it in the mirror once the handshake completes.
   task automatic program_reg(input logic [2:0] index, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (index)
         dlt_pkg::CSR_START_OFFSET: m_cfg.start_offset = data[6:0];
         dlt_pkg::CSR_BIT_TICKS:    m_cfg.bit_ticks    = data;
         dlt_pkg::CSR_STOP_TICKS:   m_cfg.stop_ticks   = data;
         dlt_pkg::CSR_BREAK_TICKS:  m_cfg.break_ticks  = data;
         dlt_pkg::CSR_MAB_TICKS:    m_cfg.mab_ticks    = data;
         dlt_pkg::CSR_GAP_TICKS:    m_cfg.gap_ticks    = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic apply_timing(input logic [15:0] offset, input logic [15:0] bit_len,
                               input logic [15:0] stop_len, input logic [15:0] brk_len,
                               input logic [15:0] mab_len, input logic [15:0] gap_len);
      program_reg(dlt_pkg::CSR_START_OFFSET, offset);
      program_reg(dlt_pkg::CSR_BIT_TICKS, bit_len);
      program_reg(dlt_pkg::CSR_STOP_TICKS, stop_len);
      program_reg(dlt_pkg::CSR_BREAK_TICKS, brk_len);
      program_reg(dlt_pkg::CSR_MAB_TICKS, mab_len);
      program_reg(dlt_pkg::CSR_GAP_TICKS, gap_len);
   endtask

   // Hold until every queued tick is taken and every line state has been seen.
   task automatic wait_drained();
      while (tick_q.size() != 0 || req_push || fresh_vld || line_expect_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Driver: hold an offered tick until it is taken, then predict its line state.
   always @(posedge clock) begin : driver
      tick_item_type nxt;
      logic          offer;
      if (reset) begin
         req_push  <= 1'b0;
         fresh_vld <= 1'b0;
      end else begin
         fresh_vld <= req_push && !req_full;
         if (req_push && !req_full) begin
            fresh_line <= predict_line_tick(drv_item);
            ticks_sent++;
         end
         if (req_push && req_full)
            full_stalls++;
         if (!req_push || !req_full) begin
            offer = tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct;
            if (offer) begin
               nxt = tick_q.pop_front();
               drv_item <= nxt;
            end
            req_push <= offer;
         end
      end
   end

   // Long receiver hold-off, counted here so the monitor only has to look at it.
   always @(posedge clock) begin : rx_hold
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_tokens) begin
         hold_left  <= RX_HOLD_CYCLES;
         hold_taken <= hold_taken + 1;
      end
   end

   // Monitor: file the newest prediction, then check the line state taken this edge.
   always @(posedge clock) begin : monitor
      dlt_pkg::res_type want;
      dlt_pkg::res_type got;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (fresh_vld)
            line_expect_q.push_back(fresh_line);
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_line_level, rsp_phase, rsp_sending_command, rsp_frame_done};
            if (line_expect_q.size() == 0) begin
               $error("line state with no tick waiting: %b", got);
               fail_count++;
            end else begin
               want = line_expect_q.pop_front();
               check_field("line_level", 2'(want.line_level), 2'(got.line_level));
               check_field("phase", want.phase, got.phase);
               check_field("sending_command", 2'(want.sending_command),
                           2'(got.sending_command));
               check_field("frame_done", 2'(want.frame_done), 2'(got.frame_done));
               levels_seen++;
               if (want.frame_done) begin
                  frames_seen++;
                  if (want.sending_command)
                     cmd_frames++;
               end
            end
         end
         rsp_pop <= hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
      end
   end

   initial begin : stimulus
      m_cfg = '{dlt_pkg::RST_START_OFFSET, dlt_pkg::RST_BIT_TICKS, dlt_pkg::RST_STOP_TICKS,
                dlt_pkg::RST_BREAK_TICKS, dlt_pkg::RST_MAB_TICKS, dlt_pkg::RST_GAP_TICKS};
      for (int s = 0; s < dlt_pkg::STORE_SLOTS; s++)
         m_slots[s] = 8'h00;
      m_phase     = dlt_pkg::PHASE_BREAK;
      m_count     = '0;
      m_bit       = dlt_pkg::BIT_START;
      m_byte      = 0;
      m_shift     = '0;
      m_sum       = '0;
      m_pend      = 1'b0;
      m_pend_cmd  = dlt_pkg::CMD_TOGGLE;
      m_pend_addr = 10'd1;
      m_cmd_on    = 1'b0;
      m_act_cmd   = dlt_pkg::CMD_TOGGLE;
      m_act_addr  = 10'd1;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset timing. The first tick latches an address request whose address is
      // out of range; later requests replace each other while pending, unknown
      // codes are dropped, and writes hit both ends of the clamped slot range.
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd0, 8'd0, dlt_pkg::CMD_ADDRESS, 10'd513));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd0, 8'd0, dlt_pkg::CMD_ADDRESS, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd0, 8'd0, dlt_pkg::CMD_ADDRESS, 10'd1023));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd0, 8'd0, dlt_pkg::CMD_ADDRESS,
                               dlt_pkg::ADDR_MAX));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd0, 8'd0, CMD_SPARE_A, 10'd7));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd511, 8'd255, CMD_SPARE_B, 10'd1023));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd0, 8'd0, dlt_pkg::CMD_TOGGLE, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd0, 8'd0, dlt_pkg::CMD_LOCK, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd0, 8'd0, dlt_pkg::CMD_UNLOCK, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd0, 8'd0, dlt_pkg::CMD_KEEPALIVE, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd0, 8'd0, dlt_pkg::CMD_SET_CHAN, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_CMD, 9'd0, 8'd0, dlt_pkg::CMD_ADDRESS, 10'd300));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_WRITE, 9'd0, 8'd255, dlt_pkg::CMD_TOGGLE, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_WRITE, 9'd511, 8'd0, dlt_pkg::CMD_TOGGLE, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_WRITE, 9'd2, 8'hA5, dlt_pkg::CMD_TOGGLE, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_WRITE, 9'd3, 8'h5A, dlt_pkg::CMD_TOGGLE, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_WRITE, 9'd9, 8'h81, dlt_pkg::CMD_TOGGLE, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_WRITE, 9'd5, 8'hFF, dlt_pkg::CMD_TOGGLE, 10'd0));
      tick_q.push_back(mk_tick(MODE_SPARE, 9'd511, 8'd255, CMD_SPARE_B, 10'd1023));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_TICK, 9'd0, 8'd0, dlt_pkg::CMD_TOGGLE, 10'd0));
      tick_q.push_back(mk_tick(dlt_pkg::MODE_TICK, 9'd511, 8'd255, CMD_SPARE_B, 10'd1023));
      wait_drained();

      // Longest lengths, offset at its top (upper data bits dropped); spare indexes do nothing.
      apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      program_reg(CSR_SPARE_A, 16'($urandom));
      program_reg(CSR_SPARE_B, 16'($urandom));
      repeat (30) tick_q.push_back(rand_tick());
      wait_drained();

      // Shrink the break below the ticks already spent so it ends at once;
      // hold the receiver off long enough to back the input up.
      apply_timing(16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      repeat (120) tick_q.push_back(rand_tick());
      hold_tokens <= hold_tokens + 1;
      wait_drained();

      // Zero lengths act as one tick; the sender idles and pauses mid-way until drained.
      send_idle_pct <= 54;
      apply_timing(16'd64, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      repeat (75) tick_q.push_back(rand_tick());
      wait_drained();
      repeat (75) tick_q.push_back(rand_tick());
      wait_drained();

      // Short random lengths with a stalling receiver.
      send_idle_pct  <= 0;
      recv_stall_pct <= 54;
      apply_timing(16'($urandom_range(127)), 16'($urandom_range(1, 2)),
                   16'($urandom_range(1, 3)), 16'($urandom_range(1, 4)),
                   16'($urandom_range(1, 3)), 16'($urandom_range(1, 4)));
      repeat (100) tick_q.push_back(rand_tick());
      wait_drained();

      // Both sides idle now and then.
      send_idle_pct  <= 7;
      recv_stall_pct <= 7;
      apply_timing(16'($urandom_range(127)), 16'd1, 16'($urandom_range(1, 2)),
                   16'($urandom_range(1, 2)), 16'd1, 16'($urandom_range(1, 2)));
      repeat (100) tick_q.push_back(rand_tick());
      wait_drained();

      // allow any stray line state to surface
      repeat (LATENCY_TAIL) @(posedge clock);

      $display("Run covered %0d ticks and %0d line states checked, %0d frames sent (%0d command).",
               ticks_sent, levels_seen, frames_seen, cmd_frames);
      $display("Input held back by a full queue for %0d cycles across six timing settings.",
               full_stalls);
      if (fail_count == 0 && line_expect_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule
